@@ rtl/cdr_pkg.sv @@
// shared types, constants and the response byte table of the captive dns responder
// no dependencies; used by cdr_parser, cdr_emitter, captive_dns_responder, cdr_checker and the testbench
package cdr_pkg;

	localparam int HDR_LEN = 12;
	localparam int TAIL_LEN = 16;
	localparam int COUNT_W = 10;
	localparam int SEQ_W = 5;
	localparam int HDR_AW = 4;
	localparam int MAX_RESPONSE_BYTES_DEF = 512;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 10'd1023;
	localparam logic [COUNT_W-1:0] HDR_LAST_IDX = 10'(HDR_LEN - 1);
	localparam logic [COUNT_W-1:0] QR_IDX = 10'd2;
	localparam int QR_BIT = 7;

	// positions in the combined header and answer sequence
	localparam logic [SEQ_W-1:0] SEQ_HDR_FIRST = 5'd0;
	localparam logic [SEQ_W-1:0] SEQ_HDR_LAST = 5'(HDR_LEN - 1);
	localparam logic [SEQ_W-1:0] SEQ_TAIL_FIRST = 5'(HDR_LEN);
	localparam logic [SEQ_W-1:0] SEQ_LAST = 5'(HDR_LEN + TAIL_LEN - 1);

	// result status codes
	localparam logic [1:0] ST_DATA = 2'd0;
	localparam logic [1:0] ST_SHORT = 2'd1;
	localparam logic [1:0] ST_NOT_QUERY = 2'd2;
	localparam logic [1:0] ST_TOO_LONG = 2'd3;

	// configuration register indexes
	localparam logic REG_ADDRESS = 1'b0;
	localparam logic REG_TTL = 1'b1;

	localparam logic [31:0] RESET_ADDRESS = 32'hC0A8_0401;
	localparam logic [31:0] RESET_TTL = 32'd86400;

	localparam logic [7:0] FLAGS_HI = 8'h81;
	localparam logic [7:0] FLAGS_LO = 8'h80;
	localparam logic [7:0] PTR_HI = 8'hC0;
	localparam logic [7:0] PTR_LO = 8'h0C;
	localparam logic [7:0] RDLEN_LO = 8'h04;

	typedef struct packed {
		logic [31:0] address;
		logic [31:0] ttl;
	} cfg_t;

	typedef struct packed {
		logic              en;
		logic [HDR_AW-1:0] addr;
		logic [7:0]        data;
	} hdr_wr_t;

	// results caused by one query byte: an optional single result first,
	// then an optional run over the header and answer sequence
	typedef struct packed {
		logic             single;
		logic [7:0]       single_byte;
		logic             single_last;
		logic [1:0]       single_status;
		logic             seq;
		logic [SEQ_W-1:0] start;
		logic [SEQ_W-1:0] stop;
	} job_t;

	function automatic logic [7:0] seq_byte(input logic [SEQ_W-1:0] pos,
			input logic [7:0] hdr, input cfg_t cfg);
		logic [7:0] v;
		case (pos)
			5'd2: v = FLAGS_HI;
			5'd3: v = FLAGS_LO;
			5'd6: v = 8'h00;
			5'd7: v = 8'h01;
			5'd12: v = PTR_HI;
			5'd13: v = PTR_LO;
			5'd14: v = 8'h00;
			5'd15: v = 8'h01;
			5'd16: v = 8'h00;
			5'd17: v = 8'h01;
			5'd18: v = cfg.ttl[31:24];
			5'd19: v = cfg.ttl[23:16];
			5'd20: v = cfg.ttl[15:8];
			5'd21: v = cfg.ttl[7:0];
			5'd22: v = 8'h00;
			5'd23: v = RDLEN_LO;
			5'd24: v = cfg.address[31:24];
			5'd25: v = cfg.address[23:16];
			5'd26: v = cfg.address[15:8];
			5'd27: v = cfg.address[7:0];
			default: v = hdr;
		endcase
		return v;
	endfunction

endpackage

@@ rtl/captive_dns_responder.sv @@
// captive dns responder: answers each dns query that is not dropped with one A record
// query bytes in on the s_ stream, response bytes out on the m_ stream
// configuration: cfg_index 0 answer address, 1 answer ttl; write on cfg_we
// a request on s_ carries one query byte, s_tlast on the last byte
// results on m_ carry a byte (m_tdata), m_tlast on the last result of a packet
// and the status in m_tuser (0 data, 1 dropped short, 2 not a query, 3 too long)
// the first result passes through the job registers and then the output register
// throughput while m_tready is high: one request per cycle while the question is
// echoed; the byte that completes the header is followed by 12 results, the last byte
// by 16 answer results, one per cycle; s_tready rises only in the cycle that moves
// the last one into the output register (the output and job registers set this rate)
// drops give one result with byte zero; a too-long query has its echoed bytes
// already sent, the receiver discards them on status 3
// reset clears counters, job and output valid and loads the default address and ttl;
// the header store needs no reset
// a stalled receiver holds the output register; one more request can be taken
// into the job registers, then s_tready drops
module captive_dns_responder #(
	parameter int MAX_RESPONSE_BYTES = cdr_pkg::MAX_RESPONSE_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] query_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] reply_byte
	output logic        m_tlast,
	output logic [1:0]  m_tuser,   // [1:0] status
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);

	cdr_pkg::cfg_t    cfg_q;
	cdr_pkg::hdr_wr_t hdr_wr;
	cdr_pkg::job_t    job;
	logic             accept;
	logic             can_accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.address <= cdr_pkg::RESET_ADDRESS;
			cfg_q.ttl <= cdr_pkg::RESET_TTL;
		end else if (cfg_we) begin
			case (cfg_index)
				cdr_pkg::REG_ADDRESS: cfg_q.address <= cfg_data;
				cdr_pkg::REG_TTL: cfg_q.ttl <= cfg_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	assign s_tready = can_accept;
	assign accept = s_tvalid && can_accept;

	cdr_parser #(
		.MAX_RESPONSE_BYTES(MAX_RESPONSE_BYTES)
	) u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.query_byte(s_tdata),
		.query_last(s_tlast),
		.hdr_wr(hdr_wr),
		.job(job)
	);

	cdr_emitter u_emitter (
		.clk(clk),
		.arst_n(arst_n),
		.load(accept),
		.job(job),
		.hdr_wr(hdr_wr),
		.cfg(cfg_q),
		.can_accept(can_accept),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.reply_byte(m_tdata),
		.reply_last(m_tlast),
		.status(m_tuser)
	);

endmodule

@@ rtl/cdr_parser.sv @@
// query parser: byte counter, drop tracking and the result job for each request
// depends on cdr_pkg
module cdr_parser #(
	parameter int MAX_RESPONSE_BYTES = cdr_pkg::MAX_RESPONSE_BYTES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [7:0]       query_byte,
	input  logic             query_last,
	output cdr_pkg::hdr_wr_t hdr_wr,
	output cdr_pkg::job_t    job
);

	localparam logic [cdr_pkg::COUNT_W-1:0] LIMIT =
		cdr_pkg::COUNT_W'(MAX_RESPONSE_BYTES - cdr_pkg::TAIL_LEN);

	logic [cdr_pkg::COUNT_W-1:0] count_q;
	logic [1:0]                  drop_q;
	logic [1:0]                  drop_n;
	logic                        in_hdr;
	logic                        hdr_done;
	logic                        echo;

	always_comb begin
		in_hdr = count_q < cdr_pkg::COUNT_W'(cdr_pkg::HDR_LEN);
		drop_n = drop_q;
		if (count_q == cdr_pkg::QR_IDX && query_byte[cdr_pkg::QR_BIT] &&
				drop_q == cdr_pkg::ST_DATA) begin
			drop_n = cdr_pkg::ST_NOT_QUERY;
		end
		hdr_done = count_q == cdr_pkg::HDR_LAST_IDX && drop_n == cdr_pkg::ST_DATA;
		echo = 1'b0;
		if (!in_hdr && drop_q == cdr_pkg::ST_DATA) begin
			if (count_q >= LIMIT) begin
				drop_n = cdr_pkg::ST_TOO_LONG;
			end else begin
				echo = 1'b1;
			end
		end

		hdr_wr.en = accept && in_hdr;
		hdr_wr.addr = count_q[cdr_pkg::HDR_AW-1:0];
		hdr_wr.data = query_byte;

		job.single = echo;
		job.single_byte = query_byte;
		job.single_last = 1'b0;
		job.single_status = cdr_pkg::ST_DATA;
		job.seq = hdr_done;
		job.start = cdr_pkg::SEQ_HDR_FIRST;
		job.stop = cdr_pkg::SEQ_HDR_LAST;
		if (query_last) begin
			if (count_q < cdr_pkg::HDR_LAST_IDX) begin
				job.single = 1'b1;
				job.single_byte = 8'h00;
				job.single_last = 1'b1;
				job.single_status = cdr_pkg::ST_SHORT;
				job.seq = 1'b0;
			end else if (drop_n != cdr_pkg::ST_DATA) begin
				job.single = 1'b1;
				job.single_byte = 8'h00;
				job.single_last = 1'b1;
				job.single_status = drop_n;
				job.seq = 1'b0;
			end else begin
				// answer record follows the header or the last echoed byte
				job.seq = 1'b1;
				job.start = hdr_done ? cdr_pkg::SEQ_HDR_FIRST : cdr_pkg::SEQ_TAIL_FIRST;
				job.stop = cdr_pkg::SEQ_LAST;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			drop_q <= cdr_pkg::ST_DATA;
		end else if (accept) begin
			if (query_last) begin
				count_q <= '0;
				drop_q <= cdr_pkg::ST_DATA;
			end else begin
				count_q <= (count_q < cdr_pkg::COUNT_MAX) ? count_q + 1'b1 : cdr_pkg::COUNT_MAX;
				drop_q <= drop_n;
			end
		end
	end

endmodule

@@ rtl/cdr_emitter.sv @@
// result sequencer: header store, job registers and the output register
// depends on cdr_pkg
module cdr_emitter (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  cdr_pkg::job_t    job,
	input  cdr_pkg::hdr_wr_t hdr_wr,
	input  cdr_pkg::cfg_t    cfg,
	output logic             can_accept,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       reply_byte,
	output logic             reply_last,
	output logic [1:0]       status
);

	logic [7:0] hdr_q [cdr_pkg::HDR_LEN];

	logic                      single_q;
	logic [7:0]                single_byte_q;
	logic                      single_last_q;
	logic [1:0]                single_status_q;
	logic                      seq_q;
	logic [cdr_pkg::SEQ_W-1:0] pos_q;
	logic [cdr_pkg::SEQ_W-1:0] stop_q;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;
	logic [1:0] out_status_q;

	logic       out_free;
	logic       finish;
	logic [7:0] hdr_rd;
	logic [7:0] seq_val;

	always_comb begin
		out_free = !out_valid_q || out_ready;
		finish = out_free && ((single_q && !seq_q) || (!single_q && seq_q && pos_q == stop_q));
		can_accept = !(single_q || seq_q) || finish;
		hdr_rd = (pos_q <= cdr_pkg::SEQ_HDR_LAST) ? hdr_q[pos_q[cdr_pkg::HDR_AW-1:0]] : 8'h00;
		seq_val = cdr_pkg::seq_byte(pos_q, hdr_rd, cfg);
	end

	always_ff @(posedge clk) begin
		if (hdr_wr.en) begin
			hdr_q[hdr_wr.addr] <= hdr_wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			single_q <= 1'b0;
			seq_q <= 1'b0;
			pos_q <= '0;
			stop_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				out_valid_q <= single_q || seq_q;
			end
			// a load only happens when the current job is idle or finishing
			if (load) begin
				single_q <= job.single;
				seq_q <= job.seq;
				pos_q <= job.start;
				stop_q <= job.stop;
			end else if (out_free) begin
				if (single_q) begin
					single_q <= 1'b0;
				end else if (seq_q) begin
					pos_q <= pos_q + 1'b1;
					if (pos_q == stop_q) begin
						seq_q <= 1'b0;
					end
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (load) begin
			single_byte_q <= job.single_byte;
			single_last_q <= job.single_last;
			single_status_q <= job.single_status;
		end
		if (out_free) begin
			if (single_q) begin
				out_byte_q <= single_byte_q;
				out_last_q <= single_last_q;
				out_status_q <= single_status_q;
			end else begin
				out_byte_q <= seq_val;
				out_last_q <= pos_q == cdr_pkg::SEQ_LAST;
				out_status_q <= cdr_pkg::ST_DATA;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign reply_byte = out_byte_q;
	assign reply_last = out_last_q;
	assign status = out_status_q;

endmodule

@@ rtl/cdr_checker.sv @@
// port-level checks of the captive dns responder, bound to the top level
// depends on cdr_pkg and captive_dns_responder
module cdr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast,
	input logic [1:0] m_tuser
);

	// a drop result is a lone zero byte that ends the packet
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != cdr_pkg::ST_DATA |-> m_tdata == 8'h00 && m_tlast)
		else $error("drop result with data or without last");

	// stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast) &&
			$stable(m_tuser))
		else $error("stalled result changed");

	// nothing comes out right after reset
	assert property (@(posedge clk)
		arst_n && !$past(arst_n) |-> !m_tvalid)
		else $error("result right after reset");

	// with nothing in flight at reset release the input is open
	assert property (@(posedge clk)
		arst_n && !$past(arst_n) |-> s_tready)
		else $error("input closed after reset");

endmodule

bind captive_dns_responder cdr_checker u_cdr_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata),
	.m_tlast(m_tlast),
	.m_tuser(m_tuser)
);

@@ verif/captive_dns_responder_tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench of captive_dns_responder: query byte stream in, reply stream checked
// depends on cdr_pkg and captive_dns_responder; a scoreboard class predicts every reply
module captive_dns_responder_tb;
	import cdr_pkg::*;

	localparam int RESP_MAX = 512;
	localparam int CYCLE_LIMIT = 600000;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic [1:0] status;
	} reply_t;

	typedef enum {Q_WELL, Q_QR, Q_ANY} query_kind_t;

	class dns_answer_model;
		logic [7:0]         hdr [HDR_LEN];
		logic [COUNT_W-1:0] count;
		logic [1:0]         drop;
		logic [31:0]        address;
		logic [31:0]        ttl;
		reply_t             replies_due [$];
		int errors, matched, n_bytes, n_answered, n_short, n_not_query, n_too_long;

		function new();
			count = '0;
			drop = ST_DATA;
			address = RESET_ADDRESS;
			ttl = RESET_TTL;
			errors = 0;
			matched = 0;
			n_bytes = 0;
			n_answered = 0;
			n_short = 0;
			n_not_query = 0;
			n_too_long = 0;
		endfunction

		function void set_reg(logic index, logic [31:0] value);
			if (index == REG_ADDRESS) begin
				address = value;
			end else begin
				ttl = value;
			end
		endfunction

		function void push(logic [7:0] d, logic l, logic [1:0] s);
			replies_due.push_back('{data: d, last: l, status: s});
		endfunction

		function void take_query(logic [7:0] b, logic last);
			logic [COUNT_W-1:0] idx;
			logic [7:0]         v;
			logic [7:0]         tail [TAIL_LEN];
			int                 i;
			idx = count;
			n_bytes++;
			if (idx < HDR_LEN)
				hdr[idx[HDR_AW-1:0]] = b;
			if (idx == QR_IDX && b[QR_BIT] && drop == ST_DATA)
				drop = ST_NOT_QUERY;
			if (idx == HDR_LAST_IDX && drop == ST_DATA) begin
				for (i = 0; i < HDR_LEN; i++) begin
					case (i)
						2: v = FLAGS_HI;
						3: v = FLAGS_LO;
						6: v = 8'h00;
						7: v = 8'h01;
						default: v = hdr[i];
					endcase
					push(v, 1'b0, ST_DATA);
				end
			end else if (idx >= HDR_LEN && drop == ST_DATA) begin
				// echo stops at the first byte that no longer fits ahead of the answer
				if (idx >= RESP_MAX - TAIL_LEN)
					drop = ST_TOO_LONG;
				else
					push(b, 1'b0, ST_DATA);
			end
			count = (idx < COUNT_MAX) ? idx + 1'b1 : COUNT_MAX;
			if (last) begin
				if (idx < HDR_LAST_IDX) begin
					push(8'h00, 1'b1, ST_SHORT);
					n_short++;
				end else if (drop != ST_DATA) begin
					push(8'h00, 1'b1, drop);
					if (drop == ST_NOT_QUERY)
						n_not_query++;
					else
						n_too_long++;
				end else begin
					tail[0] = PTR_HI;
					tail[1] = PTR_LO;
					tail[2] = 8'h00;
					tail[3] = 8'h01;
					tail[4] = 8'h00;
					tail[5] = 8'h01;
					tail[6] = ttl[31:24];
					tail[7] = ttl[23:16];
					tail[8] = ttl[15:8];
					tail[9] = ttl[7:0];
					tail[10] = 8'h00;
					tail[11] = RDLEN_LO;
					tail[12] = address[31:24];
					tail[13] = address[23:16];
					tail[14] = address[15:8];
					tail[15] = address[7:0];
					for (i = 0; i < TAIL_LEN; i++)
						push(tail[i], i == TAIL_LEN - 1, ST_DATA);
					n_answered++;
				end
				count = '0;
				drop = ST_DATA;
			end
		endfunction

		function void match_reply(logic [7:0] d, logic l, logic [1:0] s);
			reply_t w;
			if (replies_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected reply, data %h last %b status %0d", $time, d, l, s);
				return;
			end
			w = replies_due.pop_front();
			matched++;
			if (w.data !== d) begin
				errors++;
				$display("%0t: reply data expected %h actual %h", $time, w.data, d);
			end
			if (w.last !== l) begin
				errors++;
				$display("%0t: reply last expected %b actual %b", $time, w.last, l);
			end
			if (w.status !== s) begin
				errors++;
				$display("%0t: reply status expected %0d actual %0d", $time, w.status, s);
			end
		endfunction

		function int pending();
			return replies_due.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	logic [1:0]  m_tuser;
	logic        cfg_we = 1'b0;
	logic        cfg_index = REG_ADDRESS;
	logic [31:0] cfg_data = 32'h0;

	dns_answer_model board;
	logic idle_on = 1'b1;
	int   hold_reqs = 0;
	int   hold_done = 0;
	int   hold_left = 0;
	int   stall_left = 0;
	int   cycles = 0;
	int   rand_items = 0;

	captive_dns_responder #(
		.MAX_RESPONSE_BYTES(RESP_MAX)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d replies outstanding", $time, board.pending());
			$display("Regression FAIL");
			$finish;
		end
	end

	// reply side: check, then pick next ready (long hold, burst stall or ready)
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			board.match_reply(m_tdata, m_tlast, m_tuser);
		if (hold_reqs != hold_done) begin
			hold_done <= hold_done + 1;
			hold_left <= HOLD_CYCLES - 1;
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(1, 13) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// valid stays high across back-to-back requests unless a random idle gap is inserted; callers lower it when done
	task automatic send_byte(input logic [7:0] b, input logic last);
		if (idle_on && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		board.take_query(b, last);
	endtask

	task automatic send_query(input int len, input query_kind_t kind);
		logic [7:0] b;
		int         i;
		for (i = 0; i < len; i++) begin
			b = 8'($urandom);
			if (i == 2 && kind == Q_WELL)
				b[QR_BIT] = 1'b0;
			else if (i == 2 && kind == Q_QR)
				b[QR_BIT] = 1'b1;
			send_byte(b, i == len - 1);
		end
	endtask

	task automatic send_const(input int len, input logic [7:0] v);
		int i;
		for (i = 0; i < len; i++)
			send_byte(v, i == len - 1);
	endtask

	// mostly well-formed queries, some with the response bit, short ones and noise
	task automatic send_random_query();
		int r;
		int len;
		r = $urandom_range(0, 9);
		if (r < 7) begin
			len = $urandom_range(HDR_LEN, 40);
			send_query(len, Q_WELL);
		end else if (r == 7) begin
			len = $urandom_range(3, 40);
			send_query(len, Q_QR);
		end else if (r == 8) begin
			len = $urandom_range(1, HDR_LEN - 1);
			send_query(len, Q_ANY);
		end else begin
			len = $urandom_range(1, 40);
			send_query(len, Q_ANY);
		end
		rand_items += len;
	endtask

	task automatic wait_drain();
		s_tvalid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
	endtask

	task automatic set_answer(input logic [31:0] addr, input logic [31:0] ttl);
		wait_drain();
		repeat (8) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_ADDRESS;
		cfg_data <= addr;
		@(posedge clk);
		board.set_reg(REG_ADDRESS, addr);
		cfg_index <= REG_TTL;
		cfg_data <= ttl;
		@(posedge clk);
		board.set_reg(REG_TTL, ttl);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		board = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset answer: lone short byte, minimal query (28 replies), response bit set
		send_const(1, 8'hFF);
		send_const(HDR_LEN, 8'h00);
		send_const(HDR_LEN, 8'hFF);

		set_answer(32'h0000_0000, 32'hFFFF_FFFF);
		while (rand_items < 40)
			send_random_query();

		// receiver holds off while requests keep coming, so the input stalls
		hold_reqs <= hold_reqs + 1;
		send_query(40, Q_WELL);
		send_query(40, Q_WELL);
		send_query(HDR_LEN, Q_WELL);
		rand_items += 92;
		wait_drain();
		while (rand_items < 150)
			send_random_query();

		set_answer(32'hFFFF_FFFF, 32'h0000_0000);
		while (rand_items < 175)
			send_random_query();

		set_answer($urandom, $urandom);
		idle_on <= 1'b0;
		while (rand_items < 195)
			send_random_query();

		wait_drain();
		repeat (20) @(posedge clk);
		$display("%0d query bytes sent, %0d replies checked", board.n_bytes, board.matched);
		$display("%0d answered, %0d short, %0d not a query, %0d too long", board.n_answered,
			board.n_short, board.n_not_query, board.n_too_long);
		if (board.errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
